// ===== design/qvd_pkg.sv =====
// ----------------------------------------------------------------------------
// qvd_pkg: shared types and float helpers for the vector distance block
// Format codes, config struct, split float32 add and multiply (round to
// nearest even, subnormals kept) and the component decoders.
// ----------------------------------------------------------------------------
package qvd_pkg;

	localparam int LANES    = 8;
	localparam int CB_DEPTH = 256;
	localparam int CB_IDX_W = 8;

	localparam logic [3:0] FMT_FP16 = 4'd0;
	localparam logic [3:0] FMT_BF16 = 4'd1;
	localparam logic [3:0] FMT_U8   = 4'd2;
	localparam logic [3:0] FMT_S8   = 4'd3;
	localparam logic [3:0] FMT_CB1  = 4'd4;
	localparam logic [3:0] FMT_CB2  = 4'd5;
	localparam logic [3:0] FMT_CB3  = 4'd6;
	localparam logic [3:0] FMT_CB4  = 4'd7;
	localparam logic [3:0] FMT_CB8  = 4'd8;

	localparam logic [1:0] REG_CODE_FORMAT = 2'd0;
	localparam logic [1:0] REG_METRIC      = 2'd1;
	localparam logic [1:0] REG_PAIR        = 2'd2;

	localparam logic [31:0] QNAN = 32'h7FC00000;

	typedef struct packed {
		logic [3:0] fmt;
		logic       metric;
		logic       pair;
	} cfg_t;

	// aligned sum before normalization
	typedef struct packed {
		logic        nan;
		logic        inf;
		logic        isign;
		logic        sign;
		logic        zsign;
		logic [8:0]  exp;
		logic [27:0] raw;
	} add_mid_t;

	// raw mantissa product before normalization
	typedef struct packed {
		logic               nan;
		logic               inf;
		logic               sign;
		logic signed [10:0] exp;
		logic [47:0]        prod;
	} mul_mid_t;

	function automatic logic [4:0] clz27(logic [26:0] v);
		logic [4:0] c;
		logic       f;
		c = 5'd27;
		f = 1'b0;
		for (int i = 26; i >= 0; i--) begin
			if (!f && v[i]) begin
				c = 5'(26 - i);
				f = 1'b1;
			end
		end
		return c;
	endfunction

	function automatic logic [5:0] clz48(logic [47:0] v);
		logic [5:0] c;
		logic       f;
		c = 6'd48;
		f = 1'b0;
		for (int i = 47; i >= 0; i--) begin
			if (!f && v[i]) begin
				c = 6'(47 - i);
				f = 1'b1;
			end
		end
		return c;
	endfunction

	function automatic add_mid_t fadd_pre(logic [31:0] a, logic [31:0] b);
		logic        a_nan, b_nan, a_inf, b_inf, swap;
		logic [31:0] big, sml;
		logic [7:0]  eb, es;
		logic [23:0] mb, ms;
		logic [8:0]  d;
		logic [4:0]  sh;
		logic [53:0] ext;
		logic [26:0] al;
		add_mid_t    r;
		a_nan = (&a[30:23]) && (|a[22:0]);
		b_nan = (&b[30:23]) && (|b[22:0]);
		a_inf = (&a[30:23]) && !(|a[22:0]);
		b_inf = (&b[30:23]) && !(|b[22:0]);
		swap = b[30:0] > a[30:0];
		big = swap ? b : a;
		sml = swap ? a : b;
		eb = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
		es = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
		mb = {|big[30:23], big[22:0]};
		ms = {|sml[30:23], sml[22:0]};
		d = {1'b0, eb} - {1'b0, es};
		sh = (d > 9'd31) ? 5'd31 : d[4:0];
		ext = {ms, 3'b000, 27'd0} >> sh;
		al = ext[53:27] | {26'd0, |ext[26:0]};
		if (big[31] == sml[31])
			r.raw = {1'b0, mb, 3'b000} + {1'b0, al};
		else
			r.raw = {1'b0, mb, 3'b000} - {1'b0, al};
		r.exp = {1'b0, eb};
		r.sign = big[31];
		r.zsign = a[31] & b[31];
		r.nan = a_nan | b_nan | (a_inf & b_inf & (a[31] != b[31]));
		r.inf = a_inf | b_inf;
		r.isign = a_inf ? a[31] : b[31];
		return r;
	endfunction

	function automatic logic [31:0] fadd_post(add_mid_t m);
		logic [26:0] n;
		logic [9:0]  e;
		logic [8:0]  lim;
		logic [4:0]  lz, sh;
		logic [7:0]  ef;
		logic        up;
		logic [31:0] res;
		if (m.raw[27]) begin
			n = {m.raw[27:2], m.raw[1] | m.raw[0]};
			e = 10'(m.exp) + 10'd1;
		end else begin
			lz = clz27(m.raw[26:0]);
			lim = m.exp - 9'd1;
			sh = (9'(lz) < lim) ? lz : lim[4:0];
			n = m.raw[26:0] << sh;
			e = 10'(m.exp) - 10'(sh);
		end
		ef = n[26] ? e[7:0] : 8'd0;
		up = n[2] & (n[1] | n[0] | n[3]);
		if (m.nan)
			res = QNAN;
		else if (m.inf)
			res = {m.isign, 8'hFF, 23'd0};
		else if (m.raw == 28'd0)
			res = {m.zsign, 31'd0};
		else if (e >= 10'd255)
			res = {m.sign, 8'hFF, 23'd0};
		else
			res = {m.sign, ef, n[25:3]} + {31'd0, up};
		return res;
	endfunction

	function automatic mul_mid_t fmul_pre(logic [31:0] a, logic [31:0] b);
		logic       a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
		logic [7:0] ea, eb;
		logic [23:0] ma, mb;
		mul_mid_t   r;
		a_nan = (&a[30:23]) && (|a[22:0]);
		b_nan = (&b[30:23]) && (|b[22:0]);
		a_inf = (&a[30:23]) && !(|a[22:0]);
		b_inf = (&b[30:23]) && !(|b[22:0]);
		a_zero = a[30:0] == 31'd0;
		b_zero = b[30:0] == 31'd0;
		ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
		eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
		ma = {|a[30:23], a[22:0]};
		mb = {|b[30:23], b[22:0]};
		r.prod = {24'd0, ma} * {24'd0, mb};
		r.exp = $signed({3'b000, ea}) + $signed({3'b000, eb}) - 11'sd127;
		r.sign = a[31] ^ b[31];
		r.nan = a_nan | b_nan | (a_inf & b_zero) | (b_inf & a_zero);
		r.inf = a_inf | b_inf;
		return r;
	endfunction

	function automatic logic [31:0] fmul_post(mul_mid_t m);
		logic [5:0]         lz, shr;
		logic signed [10:0] er, dn;
		logic [47:0]        q, r;
		logic [95:0]        ext;
		logic               st, up;
		logic [7:0]         ef;
		logic [31:0]        res;
		lz = clz48(m.prod);
		q = m.prod << lz;
		er = m.exp + 11'sd1 - $signed({5'd0, lz});
		dn = 11'sd1 - er;
		shr = (dn > 11'sd63) ? 6'd63 : dn[5:0];
		if (er < 11'sd1) begin
			ext = {q, 48'd0} >> shr;
			r = ext[95:48];
			st = |ext[47:0];
		end else begin
			r = q;
			st = 1'b0;
		end
		ef = (er >= 11'sd1) ? er[7:0] : 8'd0;
		up = r[23] & ((|r[22:0]) | st | r[24]);
		if (m.nan)
			res = QNAN;
		else if (m.inf)
			res = {m.sign, 8'hFF, 23'd0};
		else if (m.prod == 48'd0)
			res = {m.sign, 31'd0};
		else if (er >= 11'sd255)
			res = {m.sign, 8'hFF, 23'd0};
		else
			res = {m.sign, ef, r[46:24]} + {31'd0, up};
		return res;
	endfunction

	function automatic logic [31:0] half_to_float(logic [15:0] h);
		logic [4:0]  e;
		logic [9:0]  m;
		logic [3:0]  p, k;
		logic [9:0]  mn;
		logic [7:0]  e32;
		logic [31:0] res;
		e = h[14:10];
		m = h[9:0];
		p = 4'd0;
		for (int i = 0; i < 10; i++) begin
			if (m[i])
				p = 4'(i);
		end
		k = 4'd10 - p;
		mn = m << k;
		e32 = 8'd113 - 8'(k);
		if (e == 5'd0) begin
			if (m == 10'd0)
				res = {h[15], 31'd0};
			else
				res = {h[15], e32, mn, 13'd0};
		end else if (e == 5'h1F) begin
			res = {h[15], 8'hFF, m, 13'd0} | ((m != 10'd0) ? 32'h00400000 : 32'd0);
		end else begin
			res = {h[15], 8'(e) + 8'd112, m, 13'd0};
		end
		return res;
	endfunction

	// small integer magnitude to float, exact
	function automatic logic [31:0] byte_to_float(logic s, logic [7:0] mg);
		logic [3:0]  p;
		logic [22:0] t;
		logic [31:0] res;
		p = 4'd0;
		for (int i = 0; i < 8; i++) begin
			if (mg[i])
				p = 4'(i);
		end
		t = {mg, 15'd0};
		t = t << (4'd8 - p);
		if (mg == 8'd0)
			res = 32'd0;
		else
			res = {s, 8'd127 + 8'(p), t};
		return res;
	endfunction

	function automatic logic [15:0] half_word(logic [63:0] lo, logic [63:0] hi, logic [2:0] j);
		logic [63:0] w;
		w = j[2] ? hi : lo;
		return 16'(w >> {j[1:0], 4'b0000});
	endfunction

	function automatic logic [7:0] byte_of(logic [63:0] lo, logic [2:0] j);
		return 8'(lo >> {j, 3'b000});
	endfunction

	function automatic logic [CB_IDX_W-1:0] cb_index(logic [3:0] fmt, logic [63:0] lo,
		logic [2:0] j);
		logic [CB_IDX_W-1:0] idx;
		unique case (fmt)
			FMT_CB1: idx = 8'(lo >> j) & 8'h1;
			FMT_CB2: idx = 8'(lo >> {j, 1'b0}) & 8'h3;
			FMT_CB3: idx = 8'(lo >> (6'({j, 1'b0}) + 6'(j))) & 8'h7;
			FMT_CB4: idx = 8'(lo >> {j, 2'b00}) & 8'hF;
			FMT_CB8: idx = byte_of(lo, j);
			default: idx = '0;
		endcase
		return idx;
	endfunction

	function automatic logic [31:0] decode(logic [3:0] fmt, logic [15:0] h, logic [7:0] by,
		logic [31:0] cb, logic ok);
		logic [31:0] v;
		unique case (fmt)
			FMT_FP16: v = half_to_float(h);
			FMT_BF16: v = {h, 16'd0};
			FMT_U8:   v = byte_to_float(1'b0, by);
			FMT_S8:   v = by[7] ? byte_to_float(1'b0, by - 8'd128)
			                    : byte_to_float(1'b1, 8'd128 - by);
			FMT_CB1, FMT_CB2, FMT_CB3, FMT_CB4, FMT_CB8: v = ok ? cb : 32'd0;
			default:  v = 32'd0;
		endcase
		return v;
	endfunction

endpackage

// ===== design/quantized_vector_distance.sv =====
// ----------------------------------------------------------------------------
// quantized_vector_distance: streaming distance over scalar-quantized codes
// Top level: input stage, lane array, merge tree and output register.
// ----------------------------------------------------------------------------
// Does not take items back to back: each lane accumulator closes its loop
// through a float adder split over two stages, so a new group may follow
// only after the previous sum has been written back. A codebook load takes
// the same slot. A result waiting in the output register blocks nothing until
// the next result reaches the end of the merge tree; only then does the whole
// pipeline, input included, hold its contents until the waiting result is
// taken. Codebook entries are replicated per lane and operand, and an entry
// must be loaded before any group indexes it.
module quantized_vector_distance #(
	parameter int CODEBOOK_DEPTH = qvd_pkg::CB_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic        cmd,
	input  logic [63:0] code_lo,
	input  logic [63:0] code_hi,
	input  logic [63:0] code2_lo,
	input  logic [63:0] code2_hi,
	input  logic [63:0] query_01,
	input  logic [63:0] query_23,
	input  logic [63:0] query_45,
	input  logic [63:0] query_67,
	input  logic        last,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [31:0] distance_bits,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [3:0]  cfg_data
);

	localparam int AW = $clog2(CODEBOOK_DEPTH);
	localparam logic [qvd_pkg::CB_IDX_W:0] DEPTH_W = (qvd_pkg::CB_IDX_W + 1)'(CODEBOOK_DEPTH);

	qvd_pkg::cfg_t                       cfg_q;
	logic                                adv, accept, gap_q, out_load;
	logic                                valid_s1, cmd_s1, last_s1;
	logic [63:0]                         lo_s1, hi_s1, lo2_s1, hi2_s1;
	logic [qvd_pkg::LANES-1:0][31:0]     q_s1;
	logic                                we;
	logic [qvd_pkg::LANES-1:0]           fin_valid;
	logic [qvd_pkg::LANES-1:0][31:0]     fin_data;
	logic                                sum_valid;
	logic [31:0]                         sum_bits;

	assign cfg_ready = 1'b1;
	// output register can take a new value
	assign out_load = !result_valid || !result_stall;
	assign adv = out_load || !sum_valid;
	assign item_stall = !adv || gap_q;
	assign accept = item_valid && !item_stall;
	assign we = adv && valid_s1 && cmd_s1 && ({1'b0, lo_s1[7:0]} < DEPTH_W);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				qvd_pkg::REG_CODE_FORMAT: cfg_q.fmt <= cfg_data;
				qvd_pkg::REG_METRIC:      cfg_q.metric <= cfg_data[0];
				qvd_pkg::REG_PAIR:        cfg_q.pair <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q <= 1'b0;
			valid_s1 <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			if (adv) begin
				gap_q <= accept;
				valid_s1 <= accept;
			end
			if (out_load)
				result_valid <= sum_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd;
			last_s1 <= last;
			lo_s1 <= code_lo;
			hi_s1 <= code_hi;
			lo2_s1 <= code2_lo;
			hi2_s1 <= code2_hi;
			q_s1 <= {query_67, query_45, query_23, query_01};
		end
		if (out_load)
			distance_bits <= sum_bits;
	end

	for (genvar j = 0; j < qvd_pkg::LANES; j++) begin : g_lane
		qvd_lane #(.LANE_IDX(j), .CODEBOOK_DEPTH(CODEBOOK_DEPTH)) u_lane (
			.clk       (clk),
			.arst_n    (arst_n),
			.adv       (adv),
			.cfg       (cfg_q),
			.dv        (valid_s1 && !cmd_s1),
			.last      (last_s1),
			.lo        (lo_s1),
			.hi        (hi_s1),
			.lo2       (lo2_s1),
			.hi2       (hi2_s1),
			.qry       (q_s1[j]),
			.we        (we),
			.waddr     (lo_s1[AW-1:0]),
			.wdata     (q_s1[0]),
			.fin_valid (fin_valid[j]),
			.fin_data  (fin_data[j])
		);
	end

	qvd_reduce u_reduce (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.lanes_valid (fin_valid[0]),
		.lanes       (fin_data),
		.sum_valid   (sum_valid),
		.sum_bits    (sum_bits)
	);

`ifndef SYNTHESIS
	a_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> item_stall)
		else $error("item transfer in back-to-back cycles");

	a_lanes_agree: assert property (@(posedge clk) disable iff (!arst_n)
		(fin_valid == '0) || (fin_valid == '1))
		else $error("lanes finished out of step");

	a_nan_canon: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (distance_bits[30:23] == 8'hFF) && (distance_bits[22:0] != 23'd0))
		|-> (distance_bits == qvd_pkg::QNAN))
		else $error("non-canonical NaN result");

	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall && sum_valid) |-> item_stall)
		else $error("input open while output is blocked");
`endif

endmodule

// ===== design/qvd_ram.sv =====
// ----------------------------------------------------------------------------
// qvd_ram: generic single write, single read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module qvd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

// ===== design/qvd_lane.sv =====
// ----------------------------------------------------------------------------
// qvd_lane: one component lane
// Decodes one component of each operand, forms the difference or the plain
// pair, multiplies and accumulates into the lane sum. Two codebook replicas
// give this lane its own read ports.
// ----------------------------------------------------------------------------
module qvd_lane #(
	parameter int LANE_IDX       = 0,
	parameter int CODEBOOK_DEPTH = qvd_pkg::CB_DEPTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              adv,
	input  qvd_pkg::cfg_t                     cfg,
	input  logic                              dv,
	input  logic                              last,
	input  logic [63:0]                       lo,
	input  logic [63:0]                       hi,
	input  logic [63:0]                       lo2,
	input  logic [63:0]                       hi2,
	input  logic [31:0]                       qry,
	input  logic                              we,
	input  logic [$clog2(CODEBOOK_DEPTH)-1:0] waddr,
	input  logic [31:0]                       wdata,
	output logic                              fin_valid,
	output logic [31:0]                       fin_data
);

	localparam int AW = $clog2(CODEBOOK_DEPTH);
	localparam logic [2:0] J = 3'(LANE_IDX);
	localparam logic [qvd_pkg::CB_IDX_W:0] DEPTH_W = (qvd_pkg::CB_IDX_W + 1)'(CODEBOOK_DEPTH);

	logic [qvd_pkg::CB_IDX_W-1:0] idx_now, idxb_now, idx_s2, idxb_s2;
	logic [31:0]                  cbx, cby;
	logic [15:0]                  h_s2, hb_s2;
	logic [7:0]                   by_s2, byb_s2;
	logic [31:0]                  q_s2;
	logic                         v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic                         l_s2, l_s3, l_s4, l_s5, l_s6, l_s7, l_s8;
	logic [31:0]                  x_s3, y_s3, x_s4, y_s4, opa_s5, opb_s5, term_s7;
	qvd_pkg::add_mid_t            am_s4, acm_s8;
	qvd_pkg::mul_mid_t            mm_s6;
	logic [31:0]                  x_dec, y_dec, diff, sum, lane_q;
	logic                         okx, oky;

	assign idx_now  = qvd_pkg::cb_index(cfg.fmt, lo, J);
	assign idxb_now = qvd_pkg::cb_index(cfg.fmt, lo2, J);

	// while frozen, keep re-reading the entry of the held item
	qvd_ram #(.WIDTH(32), .DEPTH(CODEBOOK_DEPTH)) u_cbx (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (adv ? idx_now[AW-1:0] : idx_s2[AW-1:0]),
		.rdata (cbx)
	);

	qvd_ram #(.WIDTH(32), .DEPTH(CODEBOOK_DEPTH)) u_cby (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (adv ? idxb_now[AW-1:0] : idxb_s2[AW-1:0]),
		.rdata (cby)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			fin_valid <= 1'b0;
			lane_q <= 32'd0;
		end else if (adv) begin
			v_s2 <= dv;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			fin_valid <= v_s8 & l_s8;
			if (v_s8)
				lane_q <= l_s8 ? 32'd0 : sum;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			l_s2 <= last;
			l_s3 <= l_s2;
			l_s4 <= l_s3;
			l_s5 <= l_s4;
			l_s6 <= l_s5;
			l_s7 <= l_s6;
			l_s8 <= l_s7;
			idx_s2 <= idx_now;
			idxb_s2 <= idxb_now;
			h_s2 <= qvd_pkg::half_word(lo, hi, J);
			hb_s2 <= qvd_pkg::half_word(lo2, hi2, J);
			by_s2 <= qvd_pkg::byte_of(lo, J);
			byb_s2 <= qvd_pkg::byte_of(lo2, J);
			q_s2 <= qry;
			x_s3 <= x_dec;
			y_s3 <= y_dec;
			am_s4 <= qvd_pkg::fadd_pre(y_s3, {~x_s3[31], x_s3[30:0]});
			x_s4 <= x_s3;
			y_s4 <= y_s3;
			opa_s5 <= cfg.metric ? y_s4 : diff;
			opb_s5 <= cfg.metric ? x_s4 : diff;
			mm_s6 <= qvd_pkg::fmul_pre(opa_s5, opb_s5);
			term_s7 <= qvd_pkg::fmul_post(mm_s6);
			acm_s8 <= qvd_pkg::fadd_pre(lane_q, term_s7);
			fin_data <= sum;
		end
	end

	always_comb begin
		okx = {1'b0, idx_s2} < DEPTH_W;
		oky = {1'b0, idxb_s2} < DEPTH_W;
		x_dec = qvd_pkg::decode(cfg.fmt, h_s2, by_s2, cbx, okx);
		y_dec = cfg.pair ? qvd_pkg::decode(cfg.fmt, hb_s2, byb_s2, cby, oky) : q_s2;
		diff = qvd_pkg::fadd_post(am_s4);
		sum = qvd_pkg::fadd_post(acm_s8);
	end

endmodule

// ===== design/qvd_reduce.sv =====
// ----------------------------------------------------------------------------
// qvd_reduce: lane merge tree
// Sums the eight final lane values as ((l0+l4)+(l1+l5))+((l2+l6)+(l3+l7)),
// each add split over two registered stages.
// ----------------------------------------------------------------------------
module qvd_reduce (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                adv,
	input  logic                                lanes_valid,
	input  logic [qvd_pkg::LANES-1:0][31:0]     lanes,
	output logic                                sum_valid,
	output logic [31:0]                         sum_bits
);

	localparam int HALF = qvd_pkg::LANES / 2;

	qvd_pkg::add_mid_t        m1_s1 [HALF];
	logic [HALF-1:0][31:0]    r1_s2;
	qvd_pkg::add_mid_t        m2_s3 [2];
	logic [1:0][31:0]         r2_s4;
	qvd_pkg::add_mid_t        m3_s5;
	logic                     v_s1, v_s2, v_s3, v_s4, v_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			sum_valid <= 1'b0;
		end else if (adv) begin
			v_s1 <= lanes_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			sum_valid <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < HALF; i++) begin
				m1_s1[i] <= qvd_pkg::fadd_pre(lanes[i], lanes[i + HALF]);
				r1_s2[i] <= qvd_pkg::fadd_post(m1_s1[i]);
			end
			m2_s3[0] <= qvd_pkg::fadd_pre(r1_s2[0], r1_s2[1]);
			m2_s3[1] <= qvd_pkg::fadd_pre(r1_s2[2], r1_s2[3]);
			r2_s4[0] <= qvd_pkg::fadd_post(m2_s3[0]);
			r2_s4[1] <= qvd_pkg::fadd_post(m2_s3[1]);
			m3_s5 <= qvd_pkg::fadd_pre(r2_s4[0], r2_s4[1]);
			// NaN results leave the adder already in canonical form
			sum_bits <= qvd_pkg::fadd_post(m3_s5);
		end
	end

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: random and directed test of quantized_vector_distance
// Streams groups of eight code components through every code format and both
// metrics, with and without pair mode, under random gaps on both handshakes.
// A float32 model built on double arithmetic with explicit round to nearest
// even predicts each distance; results are checked in order.
// ----------------------------------------------------------------------------
module tb_top;

	typedef struct {
		logic        cmd;
		logic [63:0] code_lo;
		logic [63:0] code_hi;
		logic [63:0] code2_lo;
		logic [63:0] code2_hi;
		logic [63:0] query [4];
		logic        last;
	} group_t;

	typedef struct {
		logic [1:0] idx;
		logic [3:0] data;
	} reg_wr_t;

	logic        clk;
	logic        arst_n;
	logic        item_valid;
	logic        item_stall;
	logic        cmd;
	logic [63:0] code_lo, code_hi, code2_lo, code2_hi;
	logic [63:0] query_01, query_23, query_45, query_67;
	logic        last;
	logic        result_valid;
	logic        result_stall;
	logic [31:0] distance_bits;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [3:0]  cfg_data;

	quantized_vector_distance dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall),
		.cmd(cmd), .code_lo(code_lo), .code_hi(code_hi),
		.code2_lo(code2_lo), .code2_hi(code2_hi),
		.query_01(query_01), .query_23(query_23), .query_45(query_45), .query_67(query_67),
		.last(last),
		.result_valid(result_valid), .result_stall(result_stall),
		.distance_bits(distance_bits),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// model state
	logic [31:0] lane_acc [qvd_pkg::LANES];
	logic [31:0] centroid [qvd_pkg::CB_DEPTH];
	logic [3:0]  cur_fmt;
	logic        cur_metric;
	logic        cur_pair;

	group_t      pending_groups [$];
	reg_wr_t     pending_writes [$];
	logic [31:0] expected_dist [$];
	int          groups_queued, groups_taken;
	int          errors;
	int          cycles;
	bit          calm;

	initial clk = 1'b0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ---------------- float helpers ----------------
	function automatic logic [63:0] f32_to_f64(logic [31:0] f);
		logic [23:0] m;
		int          e;
		m = {1'b0, f[22:0]};
		if (f[30:23] == 8'hFF)
			return (f[22:0] != 0) ? 64'h7FF8000000000000 : {f[31], 11'h7FF, 52'd0};
		if (f[30:0] == 0)
			return {f[31], 63'd0};
		if (f[30:23] == 0) begin
			e = -126;
			while (!m[23]) begin
				m = m << 1;
				e--;
			end
		end else begin
			m[23] = 1'b1;
			e = int'(f[30:23]) - 127;
		end
		return {f[31], 11'(e + 1023), m[22:0], 29'd0};
	endfunction

	// round to nearest even, subnormals kept, every NaN canonical
	function automatic logic [31:0] f64_to_f32(logic [63:0] d);
		logic [63:0] m, kept, rest, half;
		int          fe, sh;
		logic        up;
		if (d[62:52] == 11'h7FF)
			return (d[51:0] != 0) ? qvd_pkg::QNAN : {d[63], 8'hFF, 23'd0};
		if (d[62:0] == 0)
			return {d[63], 31'd0};
		m = {11'd0, 1'b1, d[51:0]};
		fe = int'(d[62:52]) - 1023 + 127;
		if (fe >= 255)
			return {d[63], 8'hFF, 23'd0};
		sh = (fe >= 1) ? 29 : 29 + 1 - fe;
		if (sh > 60)
			sh = 60;
		kept = m >> sh;
		rest = m & ((64'd1 << sh) - 1);
		half = 64'd1 << (sh - 1);
		up = (rest > half) || (rest == half && kept[0]);
		if (fe >= 1)
			return {d[63], 31'({fe[7:0], kept[22:0]}) + 31'(up)};
		return {d[63], 31'(kept) + 31'(up)};
	endfunction

	function automatic logic [31:0] f_add(logic [31:0] a, logic [31:0] b);
		return f64_to_f32($realtobits($bitstoreal(f32_to_f64(a)) + $bitstoreal(f32_to_f64(b))));
	endfunction

	function automatic logic [31:0] f_mul(logic [31:0] a, logic [31:0] b);
		return f64_to_f32($realtobits($bitstoreal(f32_to_f64(a)) * $bitstoreal(f32_to_f64(b))));
	endfunction

	function automatic logic [31:0] f_sub(logic [31:0] a, logic [31:0] b);
		return f_add(a, {~b[31], b[30:0]});
	endfunction

	function automatic logic [31:0] fp16_value(logic [15:0] h);
		logic [10:0] m;
		logic [7:0]  e32;
		m = {1'b0, h[9:0]};
		if (h[14:10] == 0) begin
			if (m == 0)
				return {h[15], 31'd0};
			e32 = 8'd113;
			while (!m[10]) begin
				m = m << 1;
				e32--;
			end
			return {h[15], e32, m[9:0], 13'd0};
		end
		if (h[14:10] == 5'h1F)
			return {h[15], 8'hFF, h[9:0], 13'd0} | ((h[9:0] != 0) ? 32'h00400000 : 32'd0);
		return {h[15], 8'(h[14:10]) + 8'd112, h[9:0], 13'd0};
	endfunction

	function automatic logic [31:0] int_value(int v);
		return f64_to_f32($realtobits(real'(v)));
	endfunction

	function automatic logic [31:0] component(logic [63:0] lo, logic [63:0] hi, int j);
		logic [15:0] h16;
		logic [7:0]  by;
		h16 = 16'((j < 4 ? lo : hi) >> (16 * (j % 4)));
		by = 8'(lo >> (8 * j));
		case (cur_fmt)
			qvd_pkg::FMT_FP16: return fp16_value(h16);
			qvd_pkg::FMT_BF16: return {h16, 16'd0};
			qvd_pkg::FMT_U8:   return int_value(int'(by));
			qvd_pkg::FMT_S8:   return int_value(int'(by) - 128);
			qvd_pkg::FMT_CB1:  return centroid[(lo >> j) & 64'h1];
			qvd_pkg::FMT_CB2:  return centroid[(lo >> (2 * j)) & 64'h3];
			qvd_pkg::FMT_CB3:  return centroid[(lo >> (3 * j)) & 64'h7];
			qvd_pkg::FMT_CB4:  return centroid[(lo >> (4 * j)) & 64'hF];
			qvd_pkg::FMT_CB8:  return centroid[by];
			default:           return 32'd0;
		endcase
	endfunction

	// advance the lane sums by one transfer; a last group yields a distance
	task automatic accumulate(group_t g);
		logic [31:0] x, y, t;
		if (g.cmd) begin
			centroid[g.code_lo[7:0]] = g.query[0][31:0];
			return;
		end
		for (int j = 0; j < qvd_pkg::LANES; j++) begin
			x = component(g.code_lo, g.code_hi, j);
			y = cur_pair ? component(g.code2_lo, g.code2_hi, j)
			             : 32'(g.query[j / 2] >> (32 * (j % 2)));
			if (cur_metric) begin
				t = f_mul(y, x);
			end else begin
				t = f_sub(y, x);
				t = f_mul(t, t);
			end
			lane_acc[j] = f_add(lane_acc[j], t);
		end
		if (g.last) begin
			expected_dist.push_back(f_add(
				f_add(f_add(lane_acc[0], lane_acc[4]), f_add(lane_acc[1], lane_acc[5])),
				f_add(f_add(lane_acc[2], lane_acc[6]), f_add(lane_acc[3], lane_acc[7]))));
			for (int j = 0; j < qvd_pkg::LANES; j++)
				lane_acc[j] = 32'd0;
		end
	endtask

	task automatic report(string msg);
		$display("ERROR at cycle %0d: %s", cycles, msg);
		errors++;
	endtask

	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 19);
		if (r < 13)
			return 0;
		if (r < 18)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// mostly moderate values, some tiny, some raw bit patterns
	function automatic logic [31:0] rand_float();
		int r;
		r = $urandom_range(0, 9);
		if (r < 8)
			return {1'($urandom), 8'($urandom_range(110, 140)), 23'($urandom)};
		if (r == 8)
			return {1'($urandom), 8'd0, 23'($urandom)};
		return $urandom;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic queue_group(logic c, logic [63:0] lo, logic [63:0] hi, logic [63:0] lo2,
		logic [63:0] hi2, logic [63:0] qv, logic lst);
		group_t g;
		g.cmd = c;
		g.code_lo = lo;
		g.code_hi = hi;
		g.code2_lo = lo2;
		g.code2_hi = hi2;
		for (int k = 0; k < 4; k++)
			g.query[k] = (qv === 64'bx) ? {rand_float(), rand_float()} : qv;
		g.last = lst;
		pending_groups.push_back(g);
		groups_queued++;
	endtask

	task automatic queue_load(logic [7:0] idx, logic [31:0] val, logic lst);
		queue_group(1'b1, {rand64() & ~64'hFF} | 64'(idx), rand64(), rand64(), rand64(),
			{$urandom, val}, lst);
	endtask

	task automatic queue_random_group();
		queue_group(1'b0, rand64(), rand64(), rand64(), rand64(),
			($urandom_range(0, 7) == 0) ? rand64() : 64'bx, 1'b0);
	endtask

	task automatic wait_idle();
		while (!(groups_taken == groups_queued && expected_dist.size() == 0))
			@(posedge clk);
		repeat (24) @(posedge clk);
	endtask

	// ---------------- item driver ----------------
	group_t cur_group;
	int     item_gap;

	always @(posedge clk or negedge arst_n) begin
		bit busy;
		if (!arst_n) begin
			item_valid <= 1'b0;
			cmd <= 1'b0;
			code_lo <= '0;
			code_hi <= '0;
			code2_lo <= '0;
			code2_hi <= '0;
			query_01 <= '0;
			query_23 <= '0;
			query_45 <= '0;
			query_67 <= '0;
			last <= 1'b0;
			item_gap = 0;
		end else begin
			busy = item_valid;
			if (item_valid && !item_stall) begin
				accumulate(cur_group);
				groups_taken++;
				busy = 0;
			end
			if (!busy) begin
				if (item_gap > 0) begin
					item_gap--;
					item_valid <= 1'b0;
				end else if (pending_groups.size() > 0) begin
					cur_group = pending_groups.pop_front();
					cmd <= cur_group.cmd;
					code_lo <= cur_group.code_lo;
					code_hi <= cur_group.code_hi;
					code2_lo <= cur_group.code2_lo;
					code2_hi <= cur_group.code2_hi;
					query_01 <= cur_group.query[0];
					query_23 <= cur_group.query[1];
					query_45 <= cur_group.query[2];
					query_67 <= cur_group.query[3];
					last <= cur_group.last;
					item_valid <= 1'b1;
					item_gap = pick_gap();
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------- register writes ----------------
	int cfg_done;

	always @(posedge clk or negedge arst_n) begin
		bit      busy;
		reg_wr_t w;
		if (!arst_n) begin
			cfg_valid <= 1'b0;
			cfg_index <= qvd_pkg::REG_CODE_FORMAT;
			cfg_data <= 4'd0;
		end else begin
			busy = cfg_valid;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					qvd_pkg::REG_CODE_FORMAT: cur_fmt = cfg_data;
					qvd_pkg::REG_METRIC:      cur_metric = cfg_data[0];
					qvd_pkg::REG_PAIR:        cur_pair = cfg_data[0];
					default: ;
				endcase
				cfg_done++;
				busy = 0;
			end
			if (!busy) begin
				if (pending_writes.size() > 0) begin
					w = pending_writes.pop_front();
					cfg_index <= w.idx;
					cfg_data <= w.data;
					cfg_valid <= 1'b1;
				end else begin
					cfg_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------- result monitor ----------------
	int result_hold;

	always @(posedge clk or negedge arst_n) begin
		logic [31:0] want;
		if (!arst_n) begin
			result_stall <= 1'b0;
			result_hold = 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (expected_dist.size() == 0) begin
					report($sformatf("unexpected distance %h", distance_bits));
				end else begin
					want = expected_dist.pop_front();
					if (distance_bits !== want)
						report($sformatf("distance_bits %h, want %h", distance_bits, want));
				end
			end
			if (result_hold > 0) begin
				result_hold--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
				result_hold = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 300000) begin
			$display("timeout with %0d distances outstanding", expected_dist.size());
			$display("quantized_vector_distance test failed");
			$finish;
		end
	end

	// ---------------- stimulus ----------------
	initial begin
		reg_wr_t w;
		logic [3:0] fmt;
		int         len;
		for (int j = 0; j < qvd_pkg::LANES; j++)
			lane_acc[j] = 32'd0;
		cur_fmt = qvd_pkg::FMT_FP16;
		cur_metric = 1'b0;
		cur_pair = 1'b0;
		groups_queued = 0;
		groups_taken = 0;
		cfg_done = 0;
		errors = 0;
		cycles = 0;
		calm = 0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		#1 arst_n = 1'b1;

		// every centroid written once before any index format is used;
		// last is set on some loads and must be ignored
		for (int i = 0; i < qvd_pkg::CB_DEPTH; i++)
			queue_load(8'(i), (i == 0) ? 32'd0 : (i == 255) ? 32'h00000001 : rand_float(),
				1'($urandom));
		wait_idle();

		for (int ph = 0; ph < 14; ph++) begin
			fmt = (ph < 9) ? 4'(ph) : 4'($urandom_range(0, 8));
			calm = (ph % 4 == 3);
			w.idx = qvd_pkg::REG_CODE_FORMAT;
			w.data = fmt;
			pending_writes.push_back(w);
			w.idx = qvd_pkg::REG_METRIC;
			w.data = 4'(ph % 2);
			pending_writes.push_back(w);
			w.idx = qvd_pkg::REG_PAIR;
			w.data = 4'((ph / 2) % 2);
			pending_writes.push_back(w);
			while (pending_writes.size() > 0 || cfg_valid)
				@(posedge clk);
			@(posedge clk);

			// directed: zeros, ones, half-precision specials, extreme query,
			// a load inside an open vector
			queue_group(1'b0, '0, '0, '0, '0, '0, 1'b1);
			queue_group(1'b0, '1, '1, '1, '1, '1, 1'b1);
			queue_group(1'b0, 64'h7BFF_0001_7E01_7C00, 64'h8000_3C00_BC00_0400,
				64'h0400_BC00_3C00_8000, 64'h7C00_7E01_0001_7BFF, {2{32'h7F7FFFFF}}, 1'b0);
			queue_load(8'($urandom), rand_float(), 1'b1);
			queue_group(1'b0, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
				64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, {2{32'h00800000}}, 1'b1);

			for (int v = 0; v < 9; v++) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 8) : $urandom_range(1, 3);
				for (int k = 0; k < len; k++) begin
					if ($urandom_range(0, 15) == 0)
						queue_load(8'($urandom), rand_float(), 1'($urandom));
					queue_random_group();
				end
				pending_groups[$].last = 1'b1;
			end
			wait_idle();
		end

		if (errors == 0)
			$display("quantized_vector_distance test passed");
		else
			$display("quantized_vector_distance test failed");
		$finish;
	end

endmodule
